// File: design/svsc_pkg.sv
// Package with the widths, opcodes and shared types of the sphere contact pipeline.
package svsc_pkg;

  // Field widths of the ports.
  localparam int CRD_W = 32;
  localparam int RAD_W = 31;
  localparam int AX_W  = 18;
  localparam int FRAC  = 16;

  // Internal widths: center difference, axis products, dot, projected products.
  localparam int C_W   = CRD_W + 1;
  localparam int AP_W  = AX_W + C_W;
  localparam int DS_W  = AP_W + 2;
  localparam int DOT_W = DS_W - FRAC;
  localparam int AQ_W  = AX_W + DOT_W;

  // Distance vector (signed), its magnitude, and the split for squaring.
  localparam int D_W   = AQ_W - FRAC;
  localparam int DM_W  = D_W - 1;
  localparam int LO_W  = 32;
  localparam int DH_W  = DM_W - LO_W;

  // Sum of squares and its integer root.
  localparam int SQ_W  = 2 * DM_W + 2;
  localparam int M_W   = SQ_W / 2;
  localparam int NSQ   = M_W;

  // Unit vector quotient and dividend.
  localparam int U_W   = FRAC + 1;
  localparam int NUM_W = DM_W + FRAC;
  localparam int NDV   = U_W;

  // Radii and penetration depth.
  localparam int RS_W  = RAD_W + 1;
  localparam int RD_W  = RAD_W + 2;
  localparam int K_W   = M_W + 2;
  localparam int KM_W  = K_W - 1;
  localparam int BH_W  = KM_W - LO_W;

  // Force product, its Q46.16 value and the value after the gain of five.
  localparam int PR_W  = DM_W + KM_W;
  localparam int P_W   = PR_W - FRAC;
  localparam int P5_W  = P_W + 3;

  localparam logic [CRD_W-1:0] POS_MAX = {1'b0, {(CRD_W-1){1'b1}}};
  localparam logic [CRD_W-1:0] NEG_MIN = {1'b1, {(CRD_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_SPHERE = 2'd0,
    OP_CYL    = 2'd1,
    OP_INV    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // One input item as it enters the pipeline.
  typedef struct packed {
    op_t                     opcode;
    logic signed [CRD_W-1:0] self_x;
    logic signed [CRD_W-1:0] self_y;
    logic signed [CRD_W-1:0] self_z;
    logic        [RAD_W-1:0] self_radius;
    logic signed [CRD_W-1:0] other_x;
    logic signed [CRD_W-1:0] other_y;
    logic signed [CRD_W-1:0] other_z;
    logic        [RAD_W-1:0] other_radius;
    logic signed [AX_W-1:0]  axis_x;
    logic signed [AX_W-1:0]  axis_y;
    logic signed [AX_W-1:0]  axis_z;
  } in_t;

  // Side data that travels with an item from the distance stage onward.
  typedef struct packed {
    op_t                   op;
    logic [2:0][D_W-1:0]   d;
    logic [RS_W-1:0]       rs;
    logic [RD_W-1:0]       rdiff;
  } tag_t;

endpackage

// File: design/svsc_in_if.sv
// Input channel carrying one pair of bodies and the test opcode.
interface svsc_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [1:0]                               opcode;
  logic signed [svsc_pkg::CRD_W-1:0]        self_x;
  logic signed [svsc_pkg::CRD_W-1:0]        self_y;
  logic signed [svsc_pkg::CRD_W-1:0]        self_z;
  logic        [svsc_pkg::RAD_W-1:0]        self_radius;
  logic signed [svsc_pkg::CRD_W-1:0]        other_x;
  logic signed [svsc_pkg::CRD_W-1:0]        other_y;
  logic signed [svsc_pkg::CRD_W-1:0]        other_z;
  logic        [svsc_pkg::RAD_W-1:0]        other_radius;
  logic signed [svsc_pkg::AX_W-1:0]         axis_x;
  logic signed [svsc_pkg::AX_W-1:0]         axis_y;
  logic signed [svsc_pkg::AX_W-1:0]         axis_z;

  modport source (
    output valid, opcode, self_x, self_y, self_z, self_radius,
    output other_x, other_y, other_z, other_radius, axis_x, axis_y, axis_z,
    input  ready
  );
  modport sink (
    input  valid, opcode, self_x, self_y, self_z, self_radius,
    input  other_x, other_y, other_z, other_radius, axis_x, axis_y, axis_z,
    output ready
  );
endinterface

// File: design/svsc_out_if.sv
// Result channel carrying the hit flag and the push vector.
interface svsc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic signed [svsc_pkg::CRD_W-1:0] push_x;
  logic signed [svsc_pkg::CRD_W-1:0] push_y;
  logic signed [svsc_pkg::CRD_W-1:0] push_z;

  modport source (output valid, hit, push_x, push_y, push_z, input ready);
  modport sink (input valid, hit, push_x, push_y, push_z, output ready);
endinterface

// File: design/svsc_front.sv
// Front stages: center difference, axis projection, distance vector and sum of squares.
module svsc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  svsc_pkg::in_t              in_data,
  output logic                       out_valid,
  output logic [svsc_pkg::SQ_W-1:0]  out_sum,
  output svsc_pkg::tag_t             out_tag
);
  import svsc_pkg::*;

  logic signed [CRD_W-1:0] sv [3];
  logic signed [CRD_W-1:0] ov [3];
  logic signed [AX_W-1:0]  av [3];

  // Stage 1 registers.
  logic                    v1_r;
  logic signed [C_W-1:0]   c1_r [3];
  logic signed [AX_W-1:0]  ax1_r [3];
  op_t                     op1_r;
  logic [RS_W-1:0]         rs1_r;
  logic [RD_W-1:0]         rd1_r;
  // Stage 2 registers.
  logic                    v2_r;
  logic signed [AP_W-1:0]  p2_r [3];
  logic signed [C_W-1:0]   c2_r [3];
  logic signed [AX_W-1:0]  ax2_r [3];
  op_t                     op2_r;
  logic [RS_W-1:0]         rs2_r;
  logic [RD_W-1:0]         rd2_r;
  // Stage 3 registers.
  logic                    v3_r;
  logic signed [DOT_W-1:0] dot3_r;
  logic signed [C_W-1:0]   c3_r [3];
  logic signed [AX_W-1:0]  ax3_r [3];
  op_t                     op3_r;
  logic [RS_W-1:0]         rs3_r;
  logic [RD_W-1:0]         rd3_r;
  // Stage 4 registers.
  logic                    v4_r;
  logic signed [AQ_W-1:0]  q4_r [3];
  logic signed [C_W-1:0]   c4_r [3];
  op_t                     op4_r;
  logic [RS_W-1:0]         rs4_r;
  logic [RD_W-1:0]         rd4_r;
  // Stage 5 to 8 registers.
  logic                    v5_r, v6_r, v7_r, v8_r;
  tag_t                    tag5_r, tag6_r, tag7_r, tag8_r;
  logic [2*LO_W-1:0]       ll6_r [3];
  logic [DH_W+LO_W-1:0]    lh6_r [3];
  logic [2*DH_W-1:0]       hh6_r [3];
  logic [SQ_W-1:0]         sq7_r [3];
  logic [SQ_W-1:0]         s8_r;

  logic [DS_W-1:0]         dsum_nxt;
  logic [D_W-1:0]          d_nxt [3];
  logic [DM_W-1:0]         dm [3];

  assign sv[0] = in_data.self_x;
  assign sv[1] = in_data.self_y;
  assign sv[2] = in_data.self_z;
  assign ov[0] = in_data.other_x;
  assign ov[1] = in_data.other_y;
  assign ov[2] = in_data.other_z;
  assign av[0] = in_data.axis_x;
  assign av[1] = in_data.axis_y;
  assign av[2] = in_data.axis_z;

  // Valid bits of every stage move together on the pipeline enable.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  // Dot product sum with sign extension, then the distance vector.
  always_comb begin
    dsum_nxt = {{(DS_W-AP_W){p2_r[0][AP_W-1]}}, p2_r[0]}
             + {{(DS_W-AP_W){p2_r[1][AP_W-1]}}, p2_r[1]}
             + {{(DS_W-AP_W){p2_r[2][AP_W-1]}}, p2_r[2]};
    for (int i = 0; i < 3; i++) begin
      if (op4_r == OP_SPHERE) begin
        d_nxt[i] = {{(D_W-C_W){c4_r[i][C_W-1]}}, c4_r[i]};
      end else begin
        d_nxt[i] = q4_r[i][AQ_W-1:FRAC] - {{(D_W-C_W){c4_r[i][C_W-1]}}, c4_r[i]};
      end
      dm[i] = tag5_r.d[i][D_W-1] ? DM_W'(~tag5_r.d[i] + 1'b1) : tag5_r.d[i][DM_W-1:0];
    end
  end

  // Payload registers of the stages.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c1_r[i]  <= $signed({sv[i][CRD_W-1], sv[i]}) - $signed({ov[i][CRD_W-1], ov[i]});
        ax1_r[i] <= av[i];
        p2_r[i]  <= ax1_r[i] * c1_r[i];
        c2_r[i]  <= c1_r[i];
        ax2_r[i] <= ax1_r[i];
        c3_r[i]  <= c2_r[i];
        ax3_r[i] <= ax2_r[i];
        q4_r[i]  <= ax3_r[i] * dot3_r;
        c4_r[i]  <= c3_r[i];
        ll6_r[i] <= dm[i][LO_W-1:0] * dm[i][LO_W-1:0];
        lh6_r[i] <= dm[i][DM_W-1:LO_W] * dm[i][LO_W-1:0];
        hh6_r[i] <= dm[i][DM_W-1:LO_W] * dm[i][DM_W-1:LO_W];
        sq7_r[i] <= (SQ_W'(hh6_r[i]) << (2 * LO_W)) + (SQ_W'(lh6_r[i]) << (LO_W + 1))
                  + SQ_W'(ll6_r[i]);
      end
      op1_r <= in_data.opcode;
      rs1_r <= {1'b0, in_data.self_radius} + {1'b0, in_data.other_radius};
      rd1_r <= {2'b00, in_data.other_radius} - {2'b00, in_data.self_radius};
      op2_r <= op1_r;
      rs2_r <= rs1_r;
      rd2_r <= rd1_r;
      dot3_r <= dsum_nxt[DS_W-1:FRAC];
      op3_r <= op2_r;
      rs3_r <= rs2_r;
      rd3_r <= rd2_r;
      op4_r <= op3_r;
      rs4_r <= rs3_r;
      rd4_r <= rd3_r;
      tag5_r.op    <= op4_r;
      tag5_r.rs    <= rs4_r;
      tag5_r.rdiff <= rd4_r;
      for (int i = 0; i < 3; i++) begin
        tag5_r.d[i] <= d_nxt[i];
      end
      tag6_r <= tag5_r;
      tag7_r <= tag6_r;
      tag8_r <= tag7_r;
      s8_r   <= sq7_r[0] + sq7_r[1] + sq7_r[2];
    end
  end

  assign out_valid = v8_r;
  assign out_sum   = s8_r;
  assign out_tag   = tag8_r;
endmodule

// File: design/svsc_sqrt.sv
// Integer square root, one result bit per pipeline stage.
module svsc_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [svsc_pkg::SQ_W-1:0]  in_sum,
  input  svsc_pkg::tag_t             in_tag,
  output logic                       out_valid,
  output logic [svsc_pkg::M_W-1:0]   out_root,
  output svsc_pkg::tag_t             out_tag
);
  import svsc_pkg::*;

  logic            v_r    [NSQ];
  logic [SQ_W-1:0] rem_r  [NSQ];
  logic [M_W-1:0]  root_r [NSQ];
  tag_t            tag_r  [NSQ];

  for (genvar j = 0; j < NSQ; j++) begin : g_stage
    localparam int B = M_W - 1 - j;
    logic            v_in;
    logic [SQ_W-1:0] rem_in;
    logic [M_W-1:0]  root_in;
    tag_t            tag_in;
    logic [SQ_W+1:0] trial;
    logic            take;
    logic [SQ_W-1:0] rem_nxt;
    logic [M_W-1:0]  root_nxt;

    if (j == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_sum;
      assign root_in = '0;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign v_in    = v_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign tag_in  = tag_r[j-1];
    end

    // Keep this bit when (root + 2^B)^2 still fits under the value.
    always_comb begin
      trial    = ((SQ_W+2)'(root_in) << (B + 1)) | ((SQ_W+2)'(1) << (2 * B));
      take     = trial <= {2'b00, rem_in};
      rem_nxt  = take ? rem_in - trial[SQ_W-1:0] : rem_in;
      root_nxt = take ? (root_in | (M_W'(1) << B)) : root_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        root_r[j] <= root_nxt;
        tag_r[j]  <= tag_in;
      end
    end
  end

  assign out_valid = v_r[NSQ-1];
  assign out_root  = root_r[NSQ-1];
  assign out_tag   = tag_r[NSQ-1];
endmodule

// File: design/svsc_div.sv
// Restoring division of each distance component by the magnitude, one quotient bit per stage.
module svsc_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [svsc_pkg::M_W-1:0]             in_root,
  input  svsc_pkg::tag_t                       in_tag,
  output logic                                 out_valid,
  output logic [svsc_pkg::M_W-1:0]             out_root,
  output logic [2:0][svsc_pkg::U_W-1:0]        out_unit,
  output svsc_pkg::tag_t                       out_tag
);
  import svsc_pkg::*;

  logic                   v_r    [NDV];
  logic [2:0][NUM_W-1:0]  rem_r  [NDV];
  logic [2:0][U_W-1:0]    q_r    [NDV];
  logic [M_W-1:0]         root_r [NDV];
  tag_t                   tag_r  [NDV];

  // Dividends: the component magnitudes scaled by 2^16.
  logic [2:0][NUM_W-1:0]  num;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = in_tag.d[i][D_W-1] ? {DM_W'(~in_tag.d[i] + 1'b1), {FRAC{1'b0}}}
                                  : {in_tag.d[i][DM_W-1:0], {FRAC{1'b0}}};
    end
  end

  for (genvar j = 0; j < NDV; j++) begin : g_stage
    localparam int B = U_W - 1 - j;
    logic                  v_in;
    logic [2:0][NUM_W-1:0] rem_in;
    logic [2:0][U_W-1:0]   q_in;
    logic [M_W-1:0]        root_in;
    tag_t                  tag_in;
    logic [NUM_W+1:0]      dv;
    logic [2:0][NUM_W-1:0] rem_nxt;
    logic [2:0][U_W-1:0]   q_nxt;

    if (j == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = num;
      assign q_in    = '0;
      assign root_in = in_root;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign v_in    = v_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign q_in    = q_r[j-1];
      assign root_in = root_r[j-1];
      assign tag_in  = tag_r[j-1];
    end

    // Subtract the shifted divisor from each lane where it fits.
    always_comb begin
      dv = (NUM_W+2)'(root_in) << B;
      for (int i = 0; i < 3; i++) begin
        if ({2'b00, rem_in[i]} >= dv) begin
          rem_nxt[i] = rem_in[i] - dv[NUM_W-1:0];
          q_nxt[i]   = q_in[i] | (U_W'(1) << B);
        end else begin
          rem_nxt[i] = rem_in[i];
          q_nxt[i]   = q_in[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        q_r[j]    <= q_nxt;
        root_r[j] <= root_in;
        tag_r[j]  <= tag_in;
      end
    end
  end

  assign out_valid = v_r[NDV-1];
  assign out_root  = root_r[NDV-1];
  assign out_unit  = q_r[NDV-1];
  assign out_tag   = tag_r[NDV-1];
endmodule

// File: design/svsc_force.sv
// Hit decision, force product, gain and saturation; the last stage is the output register.
module svsc_force (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [svsc_pkg::M_W-1:0]             in_root,
  input  logic [2:0][svsc_pkg::U_W-1:0]        in_unit,
  input  svsc_pkg::tag_t                       in_tag,
  output logic                                 out_valid,
  output logic                                 out_hit,
  output logic [2:0][svsc_pkg::CRD_W-1:0]      out_push
);
  import svsc_pkg::*;

  logic                  v1_r, v2_r, v3_r, v4_r;
  logic [DM_W-1:0]       a1_r [3];
  logic [KM_W-1:0]       b1_r;
  logic [2:0]            neg1_r, neg2_r, neg3_r;
  logic                  zero1_r, zero2_r, zero3_r;
  logic                  hit1_r, hit2_r, hit3_r;
  logic                  cyl1_r, cyl2_r, cyl3_r;
  logic [2*LO_W-1:0]     ll2_r [3];
  logic [LO_W+BH_W-1:0]  lh2_r [3];
  logic [DH_W+LO_W-1:0]  hl2_r [3];
  logic [DH_W+BH_W-1:0]  hh2_r [3];
  logic [PR_W-1:0]       pr3_r [3];
  logic                  hit4_r;
  logic [2:0][CRD_W-1:0] push4_r;

  logic signed [K_W-1:0] k;
  logic [KM_W-1:0]       kmag;
  logic                  hit_nxt;
  logic                  zero_nxt;
  logic [DM_W-1:0]       a_nxt [3];
  logic [2:0]            neg_nxt;
  logic [DM_W-1:0]       dmag;
  logic                  dneg;
  logic [P_W-1:0]        p;
  logic [P5_W-1:0]       pg;
  logic [2:0][CRD_W-1:0] push_nxt;

  // Penetration depth, hit test and operand selection.
  always_comb begin
    k    = $signed({{(K_W-RS_W){1'b0}}, in_tag.rs}) - $signed({{(K_W-M_W){1'b0}}, in_root});
    kmag = k[K_W-1] ? KM_W'(~k + 1'b1) : k[KM_W-1:0];
    if (in_tag.op == OP_INV) begin
      hit_nxt = $signed({2'b00, in_root})
              > $signed({{(M_W+2-RD_W){in_tag.rdiff[RD_W-1]}}, in_tag.rdiff});
    end else begin
      hit_nxt = {2'b00, in_root} < {{(M_W+2-RS_W){1'b0}}, in_tag.rs};
    end
    zero_nxt = (in_tag.op == OP_NONE) || !hit_nxt || ((in_tag.op == OP_INV) && (in_root == '0));
    for (int i = 0; i < 3; i++) begin
      dneg = in_tag.d[i][D_W-1];
      dmag = dneg ? DM_W'(~in_tag.d[i] + 1'b1) : in_tag.d[i][DM_W-1:0];
      if (in_tag.op == OP_INV) begin
        a_nxt[i]   = DM_W'(in_unit[i]);
        neg_nxt[i] = dneg ^ k[K_W-1];
      end else if (in_tag.op == OP_CYL) begin
        a_nxt[i]   = dmag;
        neg_nxt[i] = dneg;
      end else begin
        a_nxt[i]   = dmag;
        neg_nxt[i] = !dneg && (in_tag.d[i] != '0);
      end
    end
  end

  // Gain and saturation to 32 bits.
  always_comb begin
    p  = '0;
    pg = '0;
    for (int i = 0; i < 3; i++) begin
      p  = pr3_r[i][PR_W-1:FRAC];
      pg = cyl3_r ? ((P5_W'(p) << 2) + P5_W'(p)) : P5_W'(p);
      if (zero3_r) begin
        push_nxt[i] = '0;
      end else if (!neg3_r[i]) begin
        push_nxt[i] = (pg > P5_W'(POS_MAX)) ? POS_MAX : pg[CRD_W-1:0];
      end else begin
        push_nxt[i] = (pg > P5_W'(NEG_MIN)) ? NEG_MIN : CRD_W'(~pg[CRD_W-1:0] + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Partial products of the force in stage two, summed in stage three.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a1_r[i]  <= a_nxt[i];
        ll2_r[i] <= a1_r[i][LO_W-1:0] * b1_r[LO_W-1:0];
        lh2_r[i] <= a1_r[i][LO_W-1:0] * b1_r[KM_W-1:LO_W];
        hl2_r[i] <= a1_r[i][DM_W-1:LO_W] * b1_r[LO_W-1:0];
        hh2_r[i] <= a1_r[i][DM_W-1:LO_W] * b1_r[KM_W-1:LO_W];
        pr3_r[i] <= PR_W'(ll2_r[i]) + (PR_W'(lh2_r[i]) << LO_W)
                  + (PR_W'(hl2_r[i]) << LO_W) + (PR_W'(hh2_r[i]) << (2 * LO_W));
      end
      b1_r    <= kmag;
      neg1_r  <= neg_nxt;
      zero1_r <= zero_nxt;
      hit1_r  <= hit_nxt && (in_tag.op != OP_NONE);
      cyl1_r  <= in_tag.op == OP_CYL;
      neg2_r  <= neg1_r;
      zero2_r <= zero1_r;
      hit2_r  <= hit1_r;
      cyl2_r  <= cyl1_r;
      neg3_r  <= neg2_r;
      zero3_r <= zero2_r;
      hit3_r  <= hit2_r;
      cyl3_r  <= cyl2_r;
      hit4_r  <= hit3_r;
      push4_r <= push_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_hit   = hit4_r;
  assign out_push  = push4_r;
endmodule

// File: design/sphere_vs_sphere_cylinder_contact.sv
// Top level of the sphere against sphere and cylinder contact pipeline.
// The pipeline has 8 front stages, 39 root stages
// (one root bit each), 17 division stages (one quotient bit each) and 4 force stages.
// Throughput is one item per cycle; the whole pipeline advances together and holds while a
// result waits at the output, bubbles ahead of it included.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
module sphere_vs_sphere_cylinder_contact (
  input  logic        clk,
  input  logic        rst_n,
  svsc_in_if.sink     in_ch,
  svsc_out_if.source  out_ch
);
  import svsc_pkg::*;

  in_t                   in_data;
  logic                  stage_en;
  logic                  fr_valid;
  logic [SQ_W-1:0]       fr_sum;
  tag_t                  fr_tag;
  logic                  sq_valid;
  logic [M_W-1:0]        sq_root;
  tag_t                  sq_tag;
  logic                  dv_valid;
  logic [M_W-1:0]        dv_root;
  logic [2:0][U_W-1:0]   dv_unit;
  tag_t                  dv_tag;
  logic                  fo_valid;
  logic                  fo_hit;
  logic [2:0][CRD_W-1:0] fo_push;

  // The pipeline moves whenever the output register is empty or being taken.
  assign stage_en    = !fo_valid || out_ch.ready;
  assign in_ch.ready = stage_en;

  assign in_data.opcode       = op_t'(in_ch.opcode);
  assign in_data.self_x       = in_ch.self_x;
  assign in_data.self_y       = in_ch.self_y;
  assign in_data.self_z       = in_ch.self_z;
  assign in_data.self_radius  = in_ch.self_radius;
  assign in_data.other_x      = in_ch.other_x;
  assign in_data.other_y      = in_ch.other_y;
  assign in_data.other_z      = in_ch.other_z;
  assign in_data.other_radius = in_ch.other_radius;
  assign in_data.axis_x       = in_ch.axis_x;
  assign in_data.axis_y       = in_ch.axis_y;
  assign in_data.axis_z       = in_ch.axis_z;

  svsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (stage_en),
    .in_valid  (in_ch.valid),
    .in_data   (in_data),
    .out_valid (fr_valid),
    .out_sum   (fr_sum),
    .out_tag   (fr_tag)
  );

  svsc_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (stage_en),
    .in_valid  (fr_valid),
    .in_sum    (fr_sum),
    .in_tag    (fr_tag),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  svsc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (stage_en),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_tag    (sq_tag),
    .out_valid (dv_valid),
    .out_root  (dv_root),
    .out_unit  (dv_unit),
    .out_tag   (dv_tag)
  );

  svsc_force u_force (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (stage_en),
    .in_valid  (dv_valid),
    .in_root   (dv_root),
    .in_unit   (dv_unit),
    .in_tag    (dv_tag),
    .out_valid (fo_valid),
    .out_hit   (fo_hit),
    .out_push  (fo_push)
  );

  assign out_ch.valid  = fo_valid;
  assign out_ch.hit    = fo_hit;
  assign out_ch.push_x = fo_push[0];
  assign out_ch.push_y = fo_push[1];
  assign out_ch.push_z = fo_push[2];

  // A result without a hit carries no force.
  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (fo_valid && !fo_hit) |-> (fo_push == '0))
    else $error("push vector nonzero on a result without hit");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !fo_valid)
    else $error("output valid after reset");

  // While the pipeline holds, the root and division output valid bits may not change.
  a_hold_root: assert property (@(posedge clk) disable iff (!rst_n)
    !stage_en |=> ($stable(sq_valid) && $stable(dv_valid)))
    else $error("pipeline stage moved during a stall");

  // A held result keeps its value until taken.
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fo_valid && !out_ch.ready) |=> (fo_valid && $stable(fo_push) && $stable(fo_hit)))
    else $error("stalled result changed");
endmodule

// File: tb/svsc_contact_checker.sv
// Checker that predicts the contact result of every accepted item and compares it.
`timescale 1ns / 1ps

module svsc_contact_checker (
  input  logic clk,
  input  logic rst_n,
  svsc_in_if   in_ch,
  svsc_out_if  out_ch,
  output int   fail_count,
  output int   pending_count
);
  import svsc_pkg::*;

  typedef struct {
    logic              hit;
    logic signed [31:0] push_x;
    logic signed [31:0] push_y;
    logic signed [31:0] push_z;
  } contact_t;

  contact_t expected_contacts[$];

  function automatic longint unsigned abs64(longint x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  // Clamp a signed magnitude into the 32-bit push range.
  function automatic logic [31:0] clamp_push(bit neg, longint unsigned mag);
    if (!neg) return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    if (mag > 64'h8000_0000) return 32'h8000_0000;
    return 32'(-mag);
  endfunction

  // Bit-by-bit integer square root of the squared distance.
  function automatic longint unsigned dist_root(longint unsigned a0, longint unsigned a1,
                                                longint unsigned a2);
    logic [127:0] sq;
    logic [127:0] cand;
    longint unsigned r;
    sq = 128'(a0) * 128'(a0) + 128'(a1) * 128'(a1) + 128'(a2) * 128'(a2);
    r = 0;
    for (int b = 40; b >= 0; b--) begin
      cand = 128'(r | (64'd1 << b));
      if (cand * cand <= sq) r = cand[63:0];
    end
    return r;
  endfunction

  function automatic contact_t predict_contact(in_t it);
    contact_t res;
    longint c[3], ax[3], d[3];
    longint dot, rself, rother, rs, k;
    longint unsigned m, unit, p;
    logic [31:0] push[3];
    bit neg;
    push = '{default: 32'd0};
    res.hit = 1'b0;
    if (it.opcode != OP_NONE) begin
      c[0] = longint'(it.self_x) - longint'(it.other_x);
      c[1] = longint'(it.self_y) - longint'(it.other_y);
      c[2] = longint'(it.self_z) - longint'(it.other_z);
      ax[0] = longint'(it.axis_x);
      ax[1] = longint'(it.axis_y);
      ax[2] = longint'(it.axis_z);
      rself = longint'({1'b0, it.self_radius});
      rother = longint'({1'b0, it.other_radius});
      rs = rself + rother;
      // Sphere uses the center offset; cylinders use the offset from the axis line.
      if (it.opcode == OP_SPHERE) begin
        d = c;
      end else begin
        dot = (ax[0] * c[0] + ax[1] * c[1] + ax[2] * c[2]) >>> 16;
        for (int i = 0; i < 3; i++) d[i] = ((ax[i] * dot) >>> 16) - c[i];
      end
      m = dist_root(abs64(d[0]), abs64(d[1]), abs64(d[2]));
      k = rs - longint'(m);
      if (it.opcode == OP_INV) begin
        res.hit = longint'(m) > rother - rself;
        if (res.hit && m != 0) begin
          for (int i = 0; i < 3; i++) begin
            unit = (abs64(d[i]) << 16) / m;
            p = (unit * abs64(k)) >> 16;
            push[i] = clamp_push((d[i] < 0) != (k < 0), p);
          end
        end
      end else begin
        res.hit = longint'(m) < rs;
        if (res.hit) begin
          for (int i = 0; i < 3; i++) begin
            p = (abs64(d[i]) * longint'(k)) >> 16;
            if (it.opcode == OP_CYL) begin
              p = p * 5;
              neg = d[i] < 0;
            end else begin
              neg = d[i] > 0;
            end
            push[i] = clamp_push(neg, p);
          end
        end
      end
    end
    res.push_x = push[0];
    res.push_y = push[1];
    res.push_z = push[2];
    return res;
  endfunction

  // Record a prediction for every accepted item and check every accepted result.
  always @(posedge clk) begin
    in_t it;
    contact_t want;
    if (!rst_n) begin
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        it.opcode       = op_t'(in_ch.opcode);
        it.self_x       = in_ch.self_x;
        it.self_y       = in_ch.self_y;
        it.self_z       = in_ch.self_z;
        it.self_radius  = in_ch.self_radius;
        it.other_x      = in_ch.other_x;
        it.other_y      = in_ch.other_y;
        it.other_z      = in_ch.other_z;
        it.other_radius = in_ch.other_radius;
        it.axis_x       = in_ch.axis_x;
        it.axis_y       = in_ch.axis_y;
        it.axis_z       = in_ch.axis_z;
        expected_contacts.push_back(predict_contact(it));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_contacts.size() == 0) begin
          $display("%0t: unexpected result hit=%0b push=(%0d,%0d,%0d)", $time,
                   out_ch.hit, out_ch.push_x, out_ch.push_y, out_ch.push_z);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_contacts.pop_front();
          if (out_ch.hit !== want.hit || out_ch.push_x !== want.push_x ||
              out_ch.push_y !== want.push_y || out_ch.push_z !== want.push_z) begin
            $display({"%0t: mismatch expected hit=%0b push=(%0d,%0d,%0d)",
                      " actual hit=%0b push=(%0d,%0d,%0d)"},
                     $time, want.hit, want.push_x, want.push_y, want.push_z,
                     out_ch.hit, out_ch.push_x, out_ch.push_y, out_ch.push_z);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= expected_contacts.size();
    end
  end
endmodule

// File: tb/testbench.sv
// Top of the contact pipeline testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import svsc_pkg::*;

  localparam int RANDOM_ITEMS = 1330;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 90;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   cycle_count = 0;

  svsc_in_if  in_ch();
  svsc_out_if out_ch();

  sphere_vs_sphere_cylinder_contact dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  svsc_contact_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: randomly chosen stall patterns, with one long hold-off that backs up the pipeline.
  initial begin
    int mode;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    for (int cyc = 0; ; cyc++) begin
      @(negedge clk);
      if (cyc % 80 == 0) mode = $urandom_range(0, 3);
      if (cyc >= 1000 && cyc < 1300) out_ch.ready = 1'b0;
      else case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = 1'($urandom_range(0, 1));
        2: out_ch.ready = ($urandom_range(0, 3) == 0);
        default: out_ch.ready = (cyc % 7 != 3);
      endcase
    end
  end

  function automatic logic signed [17:0] rand_axis_part();
    case ($urandom_range(0, 3))
      0: return 18'sd0;
      1: return 18'sd65536;
      2: return -18'sd65536;
      default: return 18'($urandom);
    endcase
  endfunction

  // Offer one item and hold it until it is accepted.
  task automatic offer_pair(in_t it);
    in_ch.opcode       = it.opcode;
    in_ch.self_x       = it.self_x;
    in_ch.self_y       = it.self_y;
    in_ch.self_z       = it.self_z;
    in_ch.self_radius  = it.self_radius;
    in_ch.other_x      = it.other_x;
    in_ch.other_y      = it.other_y;
    in_ch.other_z      = it.other_z;
    in_ch.other_radius = it.other_radius;
    in_ch.axis_x       = it.axis_x;
    in_ch.axis_y       = it.axis_y;
    in_ch.axis_z       = it.axis_z;
    in_ch.valid        = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic go_idle(int cycles);
    in_ch.valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Build a pair with the given opcode, offsets and radii around a random base point.
  function automatic in_t near_pair(op_t op, int dx, int dy, int dz, int r_self, int r_other,
                                    logic signed [17:0] ax, logic signed [17:0] ay,
                                    logic signed [17:0] az);
    in_t it;
    it.opcode = op;
    it.other_x = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    it.other_y = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    it.other_z = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    it.self_x = it.other_x + dx;
    it.self_y = it.other_y + dy;
    it.self_z = it.other_z + dz;
    it.self_radius = 31'(r_self);
    it.other_radius = 31'(r_other);
    it.axis_x = ax;
    it.axis_y = ay;
    it.axis_z = az;
    return it;
  endfunction

  initial begin
    in_t it;
    int burst;
    int mode;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = 2'd0;
    {in_ch.self_x, in_ch.self_y, in_ch.self_z, in_ch.other_x, in_ch.other_y,
     in_ch.other_z} = '0;
    {in_ch.self_radius, in_ch.other_radius} = '0;
    {in_ch.axis_x, in_ch.axis_y, in_ch.axis_z} = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: each opcode, field extremes, saturation and the inverse zero distance.
    offer_pair(near_pair(OP_SPHERE, 32'h0001_0000, 0, 0, 32'h0002_0000, 32'h0001_0000,
                         0, 0, 0));
    offer_pair(near_pair(OP_SPHERE, 32'h0010_0000, 0, 0, 32'h0001_0000, 32'h0001_0000,
                         0, 0, 0));
    offer_pair(near_pair(OP_CYL, 32'h0001_0000, 32'h0000_8000, 32'h0003_0000,
                         32'h0002_0000, 32'h0001_0000, 0, 0, 18'sd65536));
    offer_pair(near_pair(OP_INV, 32'h0001_0000, 0, 32'h0005_0000, 32'h0001_0000,
                         32'h0001_8000, 0, 0, 18'sd65536));
    offer_pair(near_pair(OP_INV, 0, 0, 0, 32'h0002_0000, 32'h0001_0000, 18'sd65536, 0, 0));
    offer_pair(near_pair(OP_NONE, 0, 0, 0, 32'h0002_0000, 32'h0002_0000, 0, 0, 0));
    offer_pair(near_pair(OP_CYL, 32'h03E8_0000, 32'h03E8_0000, 0, 31'h7FFF_FFFF,
                         31'h7FFF_FFFF, 0, 0, 18'sd65536));
    offer_pair(near_pair(OP_SPHERE, 32'h03E8_0000, -32'sh03E8_0000, 0, 31'h7FFF_FFFF,
                         31'h7FFF_FFFF, 0, 0, 0));
    offer_pair(near_pair(OP_INV, 32'h7000_0000, 0, 0, 0, 0, 18'sd65536, 0, 0));
    for (int op = 0; op < 4; op++) begin
      it.opcode = op_t'(op);
      it.self_x = 32'h7FFF_FFFF; it.self_y = 32'h8000_0000; it.self_z = 32'h7FFF_FFFF;
      it.other_x = 32'h8000_0000; it.other_y = 32'h7FFF_FFFF; it.other_z = 32'h8000_0000;
      it.self_radius = 31'h7FFF_FFFF; it.other_radius = 31'h7FFF_FFFF;
      it.axis_x = 18'h1FFFF; it.axis_y = 18'h20000; it.axis_z = 18'h1FFFF;
      offer_pair(it);
      it.self_x = 0; it.self_y = 0; it.self_z = 0;
      it.other_x = 0; it.other_y = 0; it.other_z = 0;
      it.self_radius = 0; it.other_radius = 0;
      it.axis_x = 18'h20000; it.axis_y = 18'h1FFFF; it.axis_z = 18'h20000;
      offer_pair(it);
    end
    wait_drained();

    // Random: mostly close pairs with random content, the rest full-range noise.
    for (int n = 0; n < RANDOM_ITEMS; ) begin
      if (n == RANDOM_ITEMS / 2) wait_drained();
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < RANDOM_ITEMS; b++, n++) begin
        mode = $urandom_range(0, 9);
        if (mode < 7) begin
          it = near_pair(op_t'($urandom_range(0, 3)),
                         int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000,
                         int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000,
                         int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000,
                         $urandom_range(0, 32'h0018_0000), $urandom_range(0, 32'h0018_0000),
                         rand_axis_part(), rand_axis_part(), rand_axis_part());
        end else begin
          it.opcode = op_t'($urandom_range(0, 3));
          it.self_x = $urandom; it.self_y = $urandom; it.self_z = $urandom;
          it.other_x = $urandom; it.other_y = $urandom; it.other_z = $urandom;
          it.self_radius = 31'($urandom); it.other_radius = 31'($urandom);
          it.axis_x = 18'($urandom); it.axis_y = 18'($urandom); it.axis_z = 18'($urandom);
        end
        offer_pair(it);
      end
      if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 12));
    end

    // Drain, let the pipeline settle, then give the verdict.
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
